// ===== design/clbw_pkg.sv =====
package clbw_pkg;

    typedef struct packed {
        logic [1:0] req_type;
        logic [7:0] data_byte;
        logic [7:0] column;
        logic [1:0] row;
    } in_beat_t;

    typedef struct packed {
        logic       reg_select;
        logic [7:0] bus_value;
        logic       last;
    } out_beat_t;

    typedef struct packed {
        logic load;
        logic tmr_start;
        logic push;
        logic advance;
    } clbw_cmd_t;

    typedef struct packed {
        logic tmr_done;
        logic out_free;
        logic last_strobe;
    } clbw_stat_t;

    localparam logic [1:0] REQ_INIT   = 2'd0;
    localparam logic [1:0] REQ_CMD    = 2'd1;
    localparam logic [1:0] REQ_CHAR   = 2'd2;
    localparam logic [1:0] REQ_CURSOR = 2'd3;

    localparam logic [1:0] ROW_FIRST  = 2'd0;
    localparam logic [1:0] ROW_SECOND = 2'd1;

    localparam logic [7:0] DDRAM_BASE  = 8'h80;
    localparam logic [7:0] LINE2_OFS   = 8'h40;
    localparam logic [7:0] NIBBLE_MASK = 8'hF0;

    localparam logic [2:0] INIT4_LEN = 3'd6;
    localparam logic [2:0] INIT8_LEN = 3'd4;

    function automatic logic [7:0] init_byte(input logic [2:0] idx, input logic four);
        logic [7:0] b;
        b = 8'h06;
        if (four) begin
            case (idx)
                3'd0:    b = 8'h33;
                3'd1:    b = 8'h32;
                3'd2:    b = 8'h28;
                3'd3:    b = 8'h0E;
                3'd4:    b = 8'h01;
                default: b = 8'h06;
            endcase
        end else begin
            case (idx)
                3'd0:    b = 8'h38;
                3'd1:    b = 8'h0E;
                3'd2:    b = 8'h01;
                default: b = 8'h06;
            endcase
        end
        return b;
    endfunction

endpackage

// ===== design/clbw_datapath.sv =====
module clbw_datapath #(
    parameter int ENABLE_HOLD_CYCLES = 50000
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_we,
    input  logic                 cfg_wdata,
    input  clbw_pkg::in_beat_t   s_beat,
    output logic                 m_valid,
    input  logic                 m_ready,
    output clbw_pkg::out_beat_t  m_beat,
    input  clbw_pkg::clbw_cmd_t  cmd,
    output clbw_pkg::clbw_stat_t stat
);

    localparam int TMR_W = $clog2(ENABLE_HOLD_CYCLES + 1);
    localparam logic [TMR_W-1:0] TMR_LOAD = TMR_W'(ENABLE_HOLD_CYCLES - 1);

    logic                mode_reg;
    clbw_pkg::in_beat_t  req_reg;
    logic [2:0]          idx_reg,  idx_next;
    logic                nib_reg,  nib_next;
    logic [TMR_W-1:0]    tmr_reg,  tmr_next;
    logic                m_valid_reg, m_valid_next;
    clbw_pkg::out_beat_t m_beat_reg;

    logic [7:0] cur_byte;
    logic [7:0] strobe_val;
    logic [2:0] byte_cnt;
    logic [7:0] col_ofs;
    logic       last_byte;
    logic       last_strobe;

    always_comb begin
        col_ofs = {4'd0, req_reg.column[3:0]};
        case (req_reg.req_type)
            clbw_pkg::REQ_INIT: begin
                cur_byte = clbw_pkg::init_byte(idx_reg, mode_reg);
                byte_cnt = mode_reg ? clbw_pkg::INIT4_LEN : clbw_pkg::INIT8_LEN;
            end
            clbw_pkg::REQ_CMD, clbw_pkg::REQ_CHAR: begin
                cur_byte = req_reg.data_byte;
                byte_cnt = 3'd1;
            end
            default: begin
                byte_cnt = 3'd1;
                if (req_reg.row == clbw_pkg::ROW_FIRST) begin
                    cur_byte = clbw_pkg::DDRAM_BASE | col_ofs;
                end else if (req_reg.row == clbw_pkg::ROW_SECOND) begin
                    cur_byte = clbw_pkg::DDRAM_BASE | clbw_pkg::LINE2_OFS | col_ofs;
                end else begin
                    cur_byte = clbw_pkg::DDRAM_BASE;
                end
            end
        endcase
        if (!mode_reg) begin
            strobe_val = cur_byte;
        end else if (!nib_reg) begin
            strobe_val = cur_byte & clbw_pkg::NIBBLE_MASK;
        end else begin
            strobe_val = {cur_byte[3:0], 4'd0};
        end
        last_byte   = (idx_reg == byte_cnt - 3'd1);
        last_strobe = last_byte && (!mode_reg || nib_reg);
    end

    always_comb begin
        idx_next = idx_reg;
        nib_next = nib_reg;
        if (cmd.load || (cmd.push && last_strobe)) begin
            idx_next = 3'd0;
            nib_next = 1'b0;
        end else if (cmd.advance) begin
            if (mode_reg && !nib_reg) begin
                nib_next = 1'b1;
            end else begin
                nib_next = 1'b0;
                idx_next = idx_reg + 3'd1;
            end
        end
        if (cmd.tmr_start) begin
            tmr_next = TMR_LOAD;
        end else if (tmr_reg != '0) begin
            tmr_next = tmr_reg - TMR_W'(1);
        end else begin
            tmr_next = tmr_reg;
        end
        m_valid_next = m_valid_reg;
        if (cmd.push) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg    <= 1'b1;
            idx_reg     <= 3'd0;
            nib_reg     <= 1'b0;
            tmr_reg     <= '0;
            m_valid_reg <= 1'b0;
            req_reg     <= '0;
        end else begin
            if (cfg_we) begin
                mode_reg <= cfg_wdata;
            end
            idx_reg     <= idx_next;
            nib_reg     <= nib_next;
            tmr_reg     <= tmr_next;
            m_valid_reg <= m_valid_next;
            if (cmd.load) begin
                req_reg <= s_beat;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.push) begin
            m_beat_reg.reg_select <= (req_reg.req_type == clbw_pkg::REQ_CHAR);
            m_beat_reg.bus_value  <= strobe_val;
            m_beat_reg.last       <= last_strobe;
        end
    end

    assign m_valid          = m_valid_reg;
    assign m_beat           = m_beat_reg;
    assign stat.tmr_done    = (tmr_reg == '0);
    assign stat.out_free    = !m_valid_reg || m_ready;
    assign stat.last_strobe = last_strobe;

    a_idx_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        idx_reg < byte_cnt)
        else $error("byte index past end of request");

    a_nib_only_four: assert property (@(posedge aclk) disable iff (!aresetn)
        nib_reg |-> mode_reg)
        else $error("low nibble pending in 8-bit mode");

    a_last_push: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.push && last_strobe) |=> (m_valid && m_beat.last && idx_reg == 3'd0))
        else $error("final strobe not flagged or index not cleared");

endmodule

// ===== design/clbw_ctrl.sv =====
module clbw_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  clbw_pkg::clbw_stat_t stat,
    output clbw_pkg::clbw_cmd_t  cmd
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_HI   = 2'd1;
    localparam logic [1:0] ST_LO   = 2'd2;
    localparam logic [1:0] ST_EMIT = 2'd3;

    logic [1:0] state_reg, state_next;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.load      = 1'b1;
                    cmd.tmr_start = 1'b1;
                    state_next    = ST_HI;
                end
            end
            ST_HI: begin
                if (stat.tmr_done) begin
                    cmd.tmr_start = 1'b1;
                    state_next    = ST_LO;
                end
            end
            ST_LO: begin
                if (stat.tmr_done) begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (stat.out_free) begin
                    cmd.push = 1'b1;
                    if (stat.last_strobe) begin
                        state_next = ST_IDLE;
                    end else begin
                        cmd.advance   = 1'b1;
                        cmd.tmr_start = 1'b1;
                        state_next    = ST_HI;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    a_accept_starts: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> state_reg == ST_HI)
        else $error("accepted beat did not start a strobe");

    a_lo_after_hi: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_LO && $past(state_reg) != ST_LO) |-> $past(state_reg) == ST_HI)
        else $error("enable low phase entered without high phase");

    a_next_strobe: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_EMIT && stat.out_free && !stat.last_strobe) |=> state_reg == ST_HI)
        else $error("next strobe not started");

endmodule

// ===== design/char_lcd_bus_writer_top.sv =====
// Each strobe steps through enable high, enable low and result push, with both enable phases
// timed by the single hold timer; a request holds the input not ready until its last strobe
// is pushed. One request is in flight at a time; 4-bit init is 12 strobes, 8-bit init 4.
// A stalled result beat holds the writer in its push step until taken.
// Reset (aresetn low, synchronous) clears the controller and output valid, and sets 4-bit mode.
module char_lcd_bus_writer_top #(
    parameter int ENABLE_HOLD_CYCLES = 50000
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                cfg_we,
    input  logic                cfg_wdata,
    input  logic                s_valid,
    output logic                s_ready,
    input  clbw_pkg::in_beat_t  s_beat,
    output logic                m_valid,
    input  logic                m_ready,
    output clbw_pkg::out_beat_t m_beat
);

    clbw_pkg::clbw_cmd_t  cmd;
    clbw_pkg::clbw_stat_t stat;

    clbw_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    clbw_datapath #(
        .ENABLE_HOLD_CYCLES (ENABLE_HOLD_CYCLES)
    ) u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_beat    (s_beat),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_beat    (m_beat),
        .cmd       (cmd),
        .stat      (stat)
    );

endmodule

// ===== test/tb_char_lcd_bus_writer_top.sv =====
module tb_char_lcd_bus_writer_top;

    localparam int HOLD         = 3;
    localparam int DRAIN_CYCLES = 2 * HOLD + 8;
    localparam int LONG_HOLD    = 400;
    localparam int CYCLE_LIMIT  = 600000;

    logic                aclk      = 1'b0;
    logic                aresetn   = 1'b0;
    logic                cfg_we    = 1'b0;
    logic                cfg_wdata = 1'b0;
    logic                s_valid   = 1'b0;
    logic                s_ready;
    clbw_pkg::in_beat_t  s_beat    = '0;
    logic                m_valid;
    logic                m_ready   = 1'b0;
    clbw_pkg::out_beat_t m_beat;

    clbw_pkg::out_beat_t pending_strobes[$];
    bit          mode_four     = 1'b1;
    bit          tx_gaps_on    = 1'b1;
    bit          rx_gaps_on    = 1'b1;
    bit          long_hold_req = 1'b0;
    int unsigned rx_hold       = 0;
    int unsigned rx_gap;
    int unsigned error_count   = 0;
    int unsigned cycle_count   = 0;

    const logic [7:0] init_bytes4[6] = '{8'h33, 8'h32, 8'h28, 8'h0E, 8'h01, 8'h06};
    const logic [7:0] init_bytes8[4] = '{8'h38, 8'h0E, 8'h01, 8'h06};

    char_lcd_bus_writer_top #(
        .ENABLE_HOLD_CYCLES(HOLD)
    ) DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg_we   (cfg_we),
        .cfg_wdata(cfg_wdata),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_beat   (s_beat),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_beat   (m_beat)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    function automatic int unsigned pick_gap(bit enabled);
        int unsigned r;
        if (!enabled) return 0;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(1, 4);
        return $urandom_range(12, 40);
    endfunction

    function automatic void push_byte_strobes(logic rs, logic [7:0] b);
        clbw_pkg::out_beat_t s;
        s.reg_select = rs;
        s.last       = 1'b0;
        if (mode_four) begin
            s.bus_value = b & clbw_pkg::NIBBLE_MASK;
            pending_strobes.push_back(s);
            s.bus_value = {b[3:0], 4'h0};
            pending_strobes.push_back(s);
        end else begin
            s.bus_value = b;
            pending_strobes.push_back(s);
        end
    endfunction

    function automatic void queue_lcd_strobes(clbw_pkg::in_beat_t rq);
        logic [7:0] pos;
        case (rq.req_type)
            clbw_pkg::REQ_INIT: begin
                if (mode_four) begin
                    foreach (init_bytes4[i]) push_byte_strobes(1'b0, init_bytes4[i]);
                end else begin
                    foreach (init_bytes8[i]) push_byte_strobes(1'b0, init_bytes8[i]);
                end
            end
            clbw_pkg::REQ_CMD:  push_byte_strobes(1'b0, rq.data_byte);
            clbw_pkg::REQ_CHAR: push_byte_strobes(1'b1, rq.data_byte);
            default: begin
                pos = clbw_pkg::DDRAM_BASE;
                if (rq.row == clbw_pkg::ROW_FIRST)
                    pos = clbw_pkg::DDRAM_BASE + {4'h0, rq.column[3:0]};
                else if (rq.row == clbw_pkg::ROW_SECOND)
                    pos = clbw_pkg::DDRAM_BASE + clbw_pkg::LINE2_OFS + {4'h0, rq.column[3:0]};
                push_byte_strobes(1'b0, pos);
            end
        endcase
        pending_strobes[pending_strobes.size() - 1].last = 1'b1;
    endfunction

    function automatic clbw_pkg::in_beat_t mk_req(logic [1:0] t, logic [7:0] d,
                                                  logic [7:0] c, logic [1:0] r);
        clbw_pkg::in_beat_t rq;
        rq.req_type  = t;
        rq.data_byte = d;
        rq.column    = c;
        rq.row       = r;
        return rq;
    endfunction

    always @(posedge aclk) begin
        clbw_pkg::out_beat_t exp_s;
        if (aresetn) begin
            if (m_valid && m_ready) begin
                if (pending_strobes.size() == 0) begin
                    $error("unexpected result beat rs=%0d bus=%h last=%0d",
                           m_beat.reg_select, m_beat.bus_value, m_beat.last);
                    error_count++;
                end else begin
                    exp_s = pending_strobes.pop_front();
                    if (m_beat.reg_select !== exp_s.reg_select) begin
                        $error("reg_select expected %0d actual %0d",
                               exp_s.reg_select, m_beat.reg_select);
                        error_count++;
                    end
                    if (m_beat.bus_value !== exp_s.bus_value) begin
                        $error("bus_value expected %h actual %h",
                               exp_s.bus_value, m_beat.bus_value);
                        error_count++;
                    end
                    if (m_beat.last !== exp_s.last) begin
                        $error("last expected %0d actual %0d", exp_s.last, m_beat.last);
                        error_count++;
                    end
                end
            end
            if (rx_hold != 0) begin
                m_ready <= 1'b0;
                rx_hold = rx_hold - 1;
            end else if (long_hold_req) begin
                m_ready       <= 1'b0;
                rx_hold        = LONG_HOLD;
                long_hold_req <= 1'b0;
            end else begin
                rx_gap = pick_gap(rx_gaps_on);
                if (rx_gap == 0) begin
                    m_ready <= 1'b1;
                end else begin
                    m_ready <= 1'b0;
                    rx_hold  = rx_gap - 1;
                end
            end
        end
    end

    task automatic send_request(clbw_pkg::in_beat_t rq);
        int unsigned gap;
        gap = pick_gap(tx_gaps_on);
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_beat  <= rq;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        queue_lcd_strobes(rq);
    endtask

    task automatic wait_drained();
        s_valid <= 1'b0;
        while (pending_strobes.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic set_bus_mode(bit four);
        wait_drained();
        cfg_we    <= 1'b1;
        cfg_wdata <= four;
        @(posedge aclk);
        cfg_we    <= 1'b0;
        mode_four  = four;
    endtask

    task automatic test_init_sequences();
        set_bus_mode(1'b1);
        send_request(mk_req(clbw_pkg::REQ_INIT, 8'hFF, 8'hFF, 2'd3));
        set_bus_mode(1'b0);
        send_request(mk_req(clbw_pkg::REQ_INIT, 8'h00, 8'h00, 2'd0));
    endtask

    task automatic test_command_bytes();
        send_request(mk_req(clbw_pkg::REQ_CMD, 8'h00, 8'hFF, 2'd3));
        send_request(mk_req(clbw_pkg::REQ_CMD, 8'hFF, 8'h00, 2'd0));
        set_bus_mode(1'b1);
        send_request(mk_req(clbw_pkg::REQ_CMD, 8'h00, 8'h00, 2'd0));
        send_request(mk_req(clbw_pkg::REQ_CMD, 8'hFF, 8'hFF, 2'd3));
        send_request(mk_req(clbw_pkg::REQ_CMD, 8'h5A, 8'hA5, 2'd1));
    endtask

    task automatic test_character_bytes();
        send_request(mk_req(clbw_pkg::REQ_CHAR, 8'h00, 8'hFF, 2'd2));
        send_request(mk_req(clbw_pkg::REQ_CHAR, 8'hFF, 8'h00, 2'd1));
        send_request(mk_req(clbw_pkg::REQ_CHAR, 8'hA5, 8'h5A, 2'd0));
        send_request(mk_req(clbw_pkg::REQ_CHAR, 8'h3C, 8'hC3, 2'd3));
        set_bus_mode(1'b0);
        send_request(mk_req(clbw_pkg::REQ_CHAR, 8'h00, 8'h00, 2'd0));
        send_request(mk_req(clbw_pkg::REQ_CHAR, 8'hFF, 8'hFF, 2'd3));
    endtask

    task automatic test_cursor_positions();
        send_request(mk_req(clbw_pkg::REQ_CURSOR, 8'hFF, 8'd9, clbw_pkg::ROW_FIRST));
        send_request(mk_req(clbw_pkg::REQ_CURSOR, 8'h00, 8'd31, clbw_pkg::ROW_SECOND));
        send_request(mk_req(clbw_pkg::REQ_CURSOR, 8'hFF, 8'd0, 2'd3));
        set_bus_mode(1'b1);
        send_request(mk_req(clbw_pkg::REQ_CURSOR, 8'hFF, 8'd0, clbw_pkg::ROW_FIRST));
        send_request(mk_req(clbw_pkg::REQ_CURSOR, 8'h00, 8'd15, clbw_pkg::ROW_FIRST));
        send_request(mk_req(clbw_pkg::REQ_CURSOR, 8'h00, 8'd16, clbw_pkg::ROW_FIRST));
        send_request(mk_req(clbw_pkg::REQ_CURSOR, 8'h00, 8'd255, clbw_pkg::ROW_FIRST));
        send_request(mk_req(clbw_pkg::REQ_CURSOR, 8'hFF, 8'd0, clbw_pkg::ROW_SECOND));
        send_request(mk_req(clbw_pkg::REQ_CURSOR, 8'h00, 8'd255, clbw_pkg::ROW_SECOND));
        send_request(mk_req(clbw_pkg::REQ_CURSOR, 8'h81, 8'd7, 2'd2));
        send_request(mk_req(clbw_pkg::REQ_CURSOR, 8'h7E, 8'd255, 2'd3));
    endtask

    task automatic test_random_mix();
        clbw_pkg::in_beat_t rq;
        int unsigned        r;
        for (int round = 0; round < 4; round++) begin
            set_bus_mode(round[0]);
            tx_gaps_on = (round != 1);
            rx_gaps_on = (round == 0) || (round == 2);
            for (int n = 0; n < 17; n++) begin
                r = $urandom_range(0, 99);
                rq.req_type  = (r < 10) ? clbw_pkg::REQ_INIT : (r < 40) ? clbw_pkg::REQ_CMD :
                               (r < 70) ? clbw_pkg::REQ_CHAR : clbw_pkg::REQ_CURSOR;
                rq.data_byte = 8'($urandom());
                rq.column    = 8'($urandom());
                rq.row       = 2'($urandom_range(0, 3));
                send_request(rq);
            end
        end
        tx_gaps_on = 1'b1;
        rx_gaps_on = 1'b1;
    endtask

    task automatic test_output_backpressure();
        set_bus_mode(1'b1);
        tx_gaps_on     = 1'b0;
        long_hold_req <= 1'b1;
        send_request(mk_req(clbw_pkg::REQ_INIT, 8'($urandom()), 8'($urandom()),
                            2'($urandom_range(0, 3))));
        for (int n = 0; n < 8; n++)
            send_request(mk_req(2'($urandom_range(1, 3)), 8'($urandom()), 8'($urandom()),
                                2'($urandom_range(0, 3))));
        tx_gaps_on = 1'b1;
    endtask

    task automatic test_output_backpressure_tail();
        wait_drained();
        if (error_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    endtask

    initial begin
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_init_sequences();
        test_command_bytes();
        test_character_bytes();
        test_cursor_positions();
        test_random_mix();
        test_output_backpressure();
        set_bus_mode(1'b0);
        test_output_backpressure_tail();
    end

endmodule
